/* design/amr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_pkg
// Shared field types, operation codes and status codes of the reachability
// block.
// ----------------------------------------------------------------------------
package amr_pkg;

	localparam int KIND_W   = 2;
	localparam int VTX_W    = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;
	localparam int VCOUNT_W = 5;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [VTX_W-1:0]    vtx_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [VCOUNT_W-1:0] vcount_t;

	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_REMOVE = 2'd1;
	localparam kind_t KIND_QUERY  = 2'd2;

	localparam status_t STATUS_DONE    = 2'd0;
	localparam status_t STATUS_PRESENT = 2'd1;
	localparam status_t STATUS_ABSENT  = 2'd2;

	localparam vcount_t VCOUNT_RESET = 5'd16;

endpackage

/* design/amr_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr channels
// Valid/ready channels of the reachability block: request, response and
// vertex count configuration.
// ----------------------------------------------------------------------------
interface amr_req_if import amr_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	vtx_t  from_vertex;
	vtx_t  to_vertex;

	modport source (output valid, kind, from_vertex, to_vertex, input ready);
	modport sink   (input valid, kind, from_vertex, to_vertex, output ready);
endinterface

interface amr_rsp_if import amr_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	logic    path_found;
	count_t  edge_total;

	modport source (output valid, status, path_found, edge_total, input ready);
	modport sink   (input valid, status, path_found, edge_total, output ready);
endinterface

interface amr_cfg_if import amr_pkg::*; ();
	logic    valid;
	logic    ready;
	vcount_t vertex_count;

	modport source (output valid, vertex_count, input ready);
	modport sink   (input valid, vertex_count, output ready);
endinterface

/* design/amr_row_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_row_mem
// Adjacency row memory: one write port, one read port with registered data.
// A row never written since reset reads as all zero.
// ----------------------------------------------------------------------------
module amr_row_mem #(
	parameter int VERTICES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [$clog2(VERTICES)-1:0] rd_addr,
	output logic [VERTICES-1:0]         rd_data,
	input  logic                        wr_en,
	input  logic [$clog2(VERTICES)-1:0] wr_addr,
	input  logic [VERTICES-1:0]         wr_data
);

	logic [VERTICES-1:0] mem [VERTICES];
	logic [VERTICES-1:0] row_valid_q;
	logic [VERTICES-1:0] rd_data_q;
	logic                rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_hit_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= row_valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

/* design/adjacency_matrix_reachability.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_reachability
// Directed graph on a bit adjacency matrix with edge insert, edge remove and
// path query.
// ----------------------------------------------------------------------------
// One request is in work at a time; a new request is taken while the last
// response still waits. Insert and remove read the row, write it back and
// load the response. A query grows the reached set one vertex at a time
// (issue the row read, merge the row) through the single read port of the
// row memory. No clearing pass after reset: rows carry valid bits and read
// as empty until written.
module adjacency_matrix_reachability import amr_pkg::*; #(
	parameter int VERTICES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	amr_cfg_if.sink   cfg,
	amr_req_if.sink   req,
	amr_rsp_if.source rsp
);

	localparam int IW = $clog2(VERTICES);
	localparam int EW = (IW > VTX_W ? IW : VTX_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_PICK,
		ST_MERGE,
		ST_FINISH
	} state_t;

	state_t              state_q;
	kind_t               kind_q;
	logic [IW-1:0]       u_idx_q;
	logic [IW-1:0]       v_idx_q;
	logic                v_in_q;
	logic [VERTICES-1:0] reached_q;
	logic [VERTICES-1:0] expanded_q;
	count_t              count_q;
	vcount_t             vcount_q;
	status_t             res_status_q;
	logic                res_found_q;
	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic                rsp_found_q;
	count_t              rsp_total_q;

	logic [EW-1:0]       u_ext;
	logic [EW-1:0]       v_ext;
	logic                u_in;
	logic                v_in;
	logic [VERTICES-1:0] allowed;
	logic [VERTICES-1:0] pending;
	logic [VERTICES-1:0] pick_onehot;
	logic [IW-1:0]       pick_idx;
	logic [VERTICES-1:0] bit_mask;
	logic                row_bit;
	logic                req_take;
	logic                rsp_free;

	logic                mem_rd_en;
	logic [IW-1:0]       mem_rd_addr;
	logic [VERTICES-1:0] mem_rd_data;
	logic                mem_wr_en;
	logic [VERTICES-1:0] mem_wr_data;

	assign u_ext = EW'(req.from_vertex);
	assign v_ext = EW'(req.to_vertex);
	assign u_in  = u_ext < EW'(VERTICES);
	assign v_in  = v_ext < EW'(VERTICES);

	assign req.ready = (state_q == ST_IDLE);
	assign req_take  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// Only neighbours below the configured count are followed.
	always_comb begin
		for (int i = 0; i < VERTICES; i++) begin
			allowed[i] = EW'(i) < EW'(vcount_q);
		end
	end

	// Lowest reached vertex whose row has not been merged yet.
	assign pending     = reached_q & ~expanded_q;
	assign pick_onehot = pending & (~pending + VERTICES'(1));
	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < VERTICES; i++) begin
			pick_idx = pick_idx | (pick_onehot[i] ? IW'(i) : '0);
		end
	end

	assign bit_mask = VERTICES'(1) << v_idx_q;
	assign row_bit  = mem_rd_data[v_idx_q];

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = pick_idx;
		if (req_take) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = u_ext[IW-1:0];
		end else if (state_q == ST_PICK && pending != '0) begin
			mem_rd_en = 1'b1;
		end
	end

	assign mem_wr_en = (state_q == ST_EDGE) &&
		((kind_q == KIND_INSERT && !row_bit) || (kind_q == KIND_REMOVE && row_bit));
	assign mem_wr_data = (kind_q == KIND_INSERT) ? (mem_rd_data | bit_mask)
	                                             : (mem_rd_data & ~bit_mask);

	amr_row_mem #(
		.VERTICES(VERTICES)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (u_idx_q),
		.wr_data (mem_wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_INSERT;
			u_idx_q      <= '0;
			v_idx_q      <= '0;
			v_in_q       <= 1'b0;
			reached_q    <= '0;
			expanded_q   <= '0;
			count_q      <= '0;
			vcount_q     <= VCOUNT_RESET;
			res_status_q <= STATUS_DONE;
			res_found_q  <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= STATUS_DONE;
			rsp_found_q  <= 1'b0;
			rsp_total_q  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				vcount_q <= cfg.vertex_count;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						kind_q       <= req.kind;
						u_idx_q      <= u_ext[IW-1:0];
						v_idx_q      <= v_ext[IW-1:0];
						v_in_q       <= v_in;
						res_status_q <= STATUS_DONE;
						res_found_q  <= 1'b0;
						unique case (req.kind) inside
							KIND_INSERT, KIND_REMOVE: begin
								if (u_in && v_in) begin
									state_q <= ST_EDGE;
								end else begin
									res_status_q <= STATUS_ABSENT;
									state_q      <= ST_FINISH;
								end
							end
							KIND_QUERY: begin
								// Start a fresh search from the origin.
								reached_q  <= '0;
								expanded_q <= '0;
								if (req.from_vertex == req.to_vertex) begin
									res_found_q <= 1'b1;
									state_q     <= ST_FINISH;
								end else if (!u_in) begin
									state_q <= ST_FINISH;
								end else begin
									reached_q <= VERTICES'(1) << u_ext[IW-1:0];
									state_q   <= ST_PICK;
								end
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_EDGE: begin
					if (kind_q == KIND_INSERT) begin
						if (row_bit) begin
							res_status_q <= STATUS_PRESENT;
						end else begin
							count_q <= count_q + COUNT_W'(1);
						end
					end else begin
						if (!row_bit) begin
							res_status_q <= STATUS_ABSENT;
						end else begin
							count_q <= count_q - COUNT_W'(1);
						end
					end
					state_q <= ST_FINISH;
				end
				ST_PICK: begin
					if (pending == '0) begin
						res_found_q <= v_in_q && reached_q[v_idx_q];
						state_q     <= ST_FINISH;
					end else begin
						expanded_q <= expanded_q | pick_onehot;
						state_q    <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					reached_q <= reached_q | (mem_rd_data & allowed);
					state_q   <= ST_PICK;
				end
				ST_FINISH: begin
					// Hold the result until the response register frees up.
					if (rsp_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_found_q  <= res_found_q;
						rsp_total_q  <= count_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.path_found = rsp_found_q;
	assign rsp.edge_total = rsp_total_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adjacency matrix reachability block. A short
// table of directed transactions runs first. Random phases follow, each under
// its own vertex count. Every response is compared, in order, with the
// in-bench graph predictor, or with the fixed outcome of a typed table row.
// ----------------------------------------------------------------------------
module tb_top;
	import amr_pkg::*;

	localparam int VERTICES       = 16;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int PHASES         = 9;
	localparam int ITEMS_PER_PHASE = 50;
	localparam kind_t KIND_UNUSED = 2'd3;

	typedef struct packed {
		status_t status;
		logic    path_found;
		count_t  edge_total;
	} graph_outcome_t;

	typedef struct packed {
		logic           is_cfg;
		vcount_t        cfg_value;
		kind_t          kind;
		vtx_t           from_v;
		vtx_t           to_v;
		logic           typed;
		graph_outcome_t outcome;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	int   error_count = 0;

	// Predicted graph state and configuration
	logic [VERTICES-1:0] adj_rows [VERTICES];
	count_t              edge_count;
	vcount_t             vcount_cfg;

	graph_outcome_t awaited[$];
	graph_outcome_t oldest;
	plan_row_t      directed_plan[$];

	amr_cfg_if cfg_ch ();
	amr_req_if req_ch ();
	amr_rsp_if rsp_ch ();

	adjacency_matrix_reachability #(.VERTICES(VERTICES)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic reaches(vtx_t origin, vtx_t target);
		logic [VERTICES-1:0] allowed;
		logic [VERTICES-1:0] reached;
		logic [VERTICES-1:0] grown;
		if (origin == target)
			return 1'b1;
		// counts of VERTICES and above open every column
		allowed = ~({VERTICES{1'b1}} << vcount_cfg);
		reached = '0;
		reached[origin] = 1'b1;
		while (1) begin
			grown = reached;
			for (int v = 0; v < VERTICES; v++)
				if (reached[v])
					grown = grown | (adj_rows[v] & allowed);
			if (grown == reached)
				break;
			reached = grown;
		end
		return reached[target];
	endfunction

	function automatic graph_outcome_t apply_graph_op(kind_t k, vtx_t f, vtx_t t);
		graph_outcome_t o;
		o.status     = STATUS_DONE;
		o.path_found = 1'b0;
		case (k)
			KIND_INSERT: begin
				if (adj_rows[f][t]) begin
					o.status = STATUS_PRESENT;
				end else begin
					adj_rows[f][t] = 1'b1;
					edge_count = edge_count + 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (!adj_rows[f][t]) begin
					o.status = STATUS_ABSENT;
				end else begin
					adj_rows[f][t] = 1'b0;
					edge_count = edge_count - 1'b1;
				end
			end
			KIND_QUERY: begin
				o.path_found = reaches(f, t);
			end
			default: begin
			end
		endcase
		o.edge_total = edge_count;
		return o;
	endfunction

	// Pick a stored edge, scanning from a random row and column of the matrix
	function automatic logic pick_edge(inout vtx_t u, inout vtx_t v);
		int   start_u;
		int   start_v;
		vtx_t cu;
		vtx_t cv;
		start_u = $urandom_range(VERTICES - 1);
		start_v = $urandom_range(VERTICES - 1);
		for (int i = 0; i < VERTICES; i++) begin
			cu = vtx_t'(start_u + i);
			if (adj_rows[cu] != '0) begin
				for (int j = 0; j < VERTICES; j++) begin
					cv = vtx_t'(start_v + j);
					if (adj_rows[cu][cv]) begin
						u = cu;
						v = cv;
						return 1'b1;
					end
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic plan_row_t plan_op(kind_t k, vtx_t f, vtx_t t);
		plan_row_t row;
		row        = '0;
		row.kind   = k;
		row.from_v = f;
		row.to_v   = t;
		return row;
	endfunction

	function automatic plan_row_t plan_typed(kind_t k, vtx_t f, vtx_t t, status_t s,
			logic found, count_t total);
		plan_row_t row;
		row                    = plan_op(k, f, t);
		row.typed              = 1'b1;
		row.outcome.status     = s;
		row.outcome.path_found = found;
		row.outcome.edge_total = total;
		return row;
	endfunction

	function automatic plan_row_t plan_cfg(vcount_t value);
		plan_row_t row;
		row           = '0;
		row.is_cfg    = 1'b1;
		row.cfg_value = value;
		return row;
	endfunction

	task automatic send_item(kind_t k, vtx_t f, vtx_t t, logic typed,
			graph_outcome_t typed_outcome);
		graph_outcome_t predicted;
		while (!steady && $urandom_range(99) < 17) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.kind        <= k;
		req_ch.from_vertex <= f;
		req_ch.to_vertex   <= t;
		do @(posedge clk); while (!req_ch.ready);
		predicted = apply_graph_op(k, f, t);
		awaited.push_back(typed ? typed_outcome : predicted);
	endtask

	task automatic write_vertex_count(vcount_t value);
		// hold off until the block has drained
		req_ch.valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.vertex_count <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		vcount_cfg = value;
	endtask

	always @(posedge clk)
		rsp_ch.ready <= steady || ($urandom_range(99) >= 17);

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited.size() == 0) begin
				$display("%0t: unexpected response: status %0d path_found %0d edge_total %0d",
					$time, rsp_ch.status, rsp_ch.path_found, rsp_ch.edge_total);
				error_count++;
			end else begin
				oldest = awaited.pop_front();
				if (rsp_ch.status !== oldest.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, oldest.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.path_found !== oldest.path_found) begin
					$display("%0t: path_found expected %0d actual %0d",
						$time, oldest.path_found, rsp_ch.path_found);
					error_count++;
				end
				if (rsp_ch.edge_total !== oldest.edge_total) begin
					$display("%0t: edge_total expected %0d actual %0d",
						$time, oldest.edge_total, rsp_ch.edge_total);
					error_count++;
				end
			end
		end
	end

	initial begin
		for (int c = 0; c < CYCLE_LIMIT; c++)
			@(posedge clk);
		$display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int      span;
		int      r;
		kind_t   k;
		vtx_t    f;
		vtx_t    t;
		vcount_t vc;

		arst_n              = 1'b0;
		steady              = 1'b0;
		edge_count          = '0;
		vcount_cfg          = VCOUNT_RESET;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.vertex_count <= VCOUNT_RESET;
		req_ch.valid        <= 1'b0;
		req_ch.kind         <= KIND_INSERT;
		req_ch.from_vertex  <= '0;
		req_ch.to_vertex    <= '0;
		foreach (adj_rows[i])
			adj_rows[i] = '0;

		directed_plan.push_back(plan_typed(KIND_QUERY, 4'd0, 4'd0, STATUS_DONE, 1'b1, 9'd0));
		directed_plan.push_back(plan_typed(KIND_QUERY, 4'd0, 4'd5, STATUS_DONE, 1'b0, 9'd0));
		directed_plan.push_back(plan_typed(KIND_REMOVE, 4'd3, 4'd4, STATUS_ABSENT, 1'b0, 9'd0));
		directed_plan.push_back(plan_typed(KIND_INSERT, 4'd0, 4'd15, STATUS_DONE, 1'b0, 9'd1));
		directed_plan.push_back(plan_typed(KIND_INSERT, 4'd0, 4'd15, STATUS_PRESENT, 1'b0, 9'd1));
		directed_plan.push_back(plan_op(KIND_INSERT, 4'd15, 4'd0));
		directed_plan.push_back(plan_typed(KIND_INSERT, 4'd15, 4'd15, STATUS_DONE, 1'b0, 9'd3));
		directed_plan.push_back(plan_op(KIND_INSERT, 4'd15, 4'd7));
		directed_plan.push_back(plan_op(KIND_QUERY, 4'd0, 4'd7));
		directed_plan.push_back(plan_op(KIND_QUERY, 4'd7, 4'd0));
		directed_plan.push_back(plan_typed(KIND_UNUSED, 4'd15, 4'd15, STATUS_DONE, 1'b0, 9'd4));
		directed_plan.push_back(plan_typed(KIND_REMOVE, 4'd15, 4'd15, STATUS_DONE, 1'b0, 9'd3));
		directed_plan.push_back(plan_typed(KIND_REMOVE, 4'd15, 4'd15, STATUS_ABSENT, 1'b0, 9'd3));
		directed_plan.push_back(plan_typed(KIND_QUERY, 4'd15, 4'd15, STATUS_DONE, 1'b1, 9'd3));
		directed_plan.push_back(plan_op(KIND_INSERT, 4'd7, 4'd3));
		directed_plan.push_back(plan_op(KIND_INSERT, 4'd3, 4'd9));
		directed_plan.push_back(plan_op(KIND_QUERY, 4'd0, 4'd9));
		directed_plan.push_back(plan_op(KIND_QUERY, 4'd9, 4'd0));
		directed_plan.push_back(plan_cfg(5'd1));
		directed_plan.push_back(plan_op(KIND_QUERY, 4'd0, 4'd9));
		directed_plan.push_back(plan_typed(KIND_QUERY, 4'd9, 4'd9, STATUS_DONE, 1'b1, 9'd5));
		directed_plan.push_back(plan_cfg(5'd0));
		directed_plan.push_back(plan_op(KIND_QUERY, 4'd15, 4'd0));
		directed_plan.push_back(plan_cfg(5'd31));
		directed_plan.push_back(plan_op(KIND_QUERY, 4'd0, 4'd9));
		directed_plan.push_back(plan_op(KIND_QUERY, 4'd0, 4'd10));
		directed_plan.push_back(plan_cfg(5'd16));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg)
				write_vertex_count(directed_plan[i].cfg_value);
			else
				send_item(directed_plan[i].kind, directed_plan[i].from_v,
					directed_plan[i].to_v, directed_plan[i].typed,
					directed_plan[i].outcome);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: vc = 5'd16;
				1: vc = 5'd1;
				2: vc = 5'd0;
				3: vc = 5'd31;
				4: vc = vcount_t'($urandom_range(2, 15));
				5: vc = vcount_t'($urandom_range(17, 31));
				6: vc = 5'd16;
				7: vc = vcount_t'($urandom_range(1, 16));
				default: vc = vcount_t'($urandom_range(0, 31));
			endcase
			write_vertex_count(vc);
			// one phase runs back to back on both sides
			steady = (ph == 6);
			case ($urandom_range(2))
				0: span = 3;
				1: span = 7;
				default: span = 15;
			endcase
			if (ph == 6)
				span = 15;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				r = $urandom_range(99);
				if ($urandom_range(9) == 0) begin
					f = vtx_t'($urandom_range(VERTICES - 1));
					t = vtx_t'($urandom_range(VERTICES - 1));
				end else begin
					f = vtx_t'($urandom_range(span));
					t = vtx_t'($urandom_range(span));
				end
				if (r < 40) begin
					k = KIND_INSERT;
				end else if (r < 60) begin
					k = KIND_REMOVE;
					// mostly target an edge that is stored
					if ($urandom_range(9) < 7)
						void'(pick_edge(f, t));
				end else if (r < 97) begin
					k = KIND_QUERY;
				end else begin
					k = KIND_UNUSED;
				end
				send_item(k, f, t, 1'b0, '0);
			end
		end

		steady = 1'b0;
		req_ch.valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
design/amr_pkg.sv
design/amr_channels.sv
design/amr_row_mem.sv
design/adjacency_matrix_reachability.sv
tb/tb_top.sv
